FILE: sv/record_table_with_id_recycling_assert.svh
// Assertion macros used by the checker file.
`ifndef RECORD_TABLE_WITH_ID_RECYCLING_ASSERT_SVH
`define RECORD_TABLE_WITH_ID_RECYCLING_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RTIDR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rtidr assertion failed");

// Next-cycle implication, disabled during reset.
`define RTIDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rtidr assertion failed");

`endif

FILE: sv/rtidr_pkg.sv
package rtidr_pkg;

    localparam int CMD_W    = 2;
    localparam int ID_W     = 8;
    localparam int KEY_W    = 32;
    localparam int OWNER_W  = 31;
    localparam int DATE_W   = 64;
    localparam int TIME_W   = 48;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_RSVD   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_INVALID   = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // One table entry as held in the record RAM.
    typedef struct packed {
        logic               valid;
        logic [OWNER_W-1:0] patient;
        logic [OWNER_W-1:0] doctor;
        logic [DATE_W-1:0]  date;
        logic [TIME_W-1:0]  tim;
    } t_record;

    localparam int REC_W = $bits(t_record);

endpackage

FILE: sv/rtidr_ram.sv
module rtidr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/record_table_with_id_recycling.sv
// Record table with ID recycling. Commands: add stores a record and returns its ID (a freed
// ID from the LIFO free stack first, else the live count), remove frees a live ID, lookup
// returns the record. A command runs as a transfer, then an execute step: the transfer cycle reads the record RAM
// and the free-stack RAM, then the S_EXEC state modifies, writes back and loads the result
// register; o_in_ready is high again after that. If the previous result has not been taken,
// S_EXEC holds until it is. No clearing pass after reset: IDs at or above
// live count plus stack depth were never handed out since reset, so their valid bits are
// treated as clear. Records live in one CAPACITY-deep RAM, free IDs in a second.
module record_table_with_id_recycling
    import rtidr_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [ID_W-1:0]     i_entry_id,
    input  logic [KEY_W-1:0]    i_patient_key,
    input  logic [KEY_W-1:0]    i_doctor_key,
    input  logic [DATE_W-1:0]   i_date_chars,
    input  logic [TIME_W-1:0]   i_time_chars,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [ID_W-1:0]     o_result_id,
    output logic [OWNER_W-1:0]  o_found_patient,
    output logic [OWNER_W-1:0]  o_found_doctor,
    output logic [DATE_W-1:0]   o_found_date,
    output logic [TIME_W-1:0]   o_found_time
);

    localparam int IDW  = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int EXTW = (IDW > ID_W) ? IDW : ID_W;
    localparam int CMPW = (EXTW > CW) ? EXTW : CW;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    t_cmd               r_cmd;
    logic [EXTW-1:0]    r_id;
    logic [KEY_W-1:0]   r_patient;
    logic [KEY_W-1:0]   r_doctor;
    logic [DATE_W-1:0]  r_date;
    logic [TIME_W-1:0]  r_time;
    logic [CW-1:0]      r_live, n_live;
    logic [CW-1:0]      r_depth, n_depth;

    logic                r_out_valid;
    t_status             r_status, n_status;
    logic [ID_W-1:0]     r_rid, n_rid;
    logic [OWNER_W-1:0]  r_fp, n_fp;
    logic [OWNER_W-1:0]  r_fd, n_fd;
    logic [DATE_W-1:0]   r_fdate, n_fdate;
    logic [TIME_W-1:0]   r_ftime, n_ftime;

    logic            in_xfer;
    logic            exec_done;
    logic [EXTW-1:0] id_in_ext;
    logic [CW-1:0]   depth_m1;
    logic [CW-1:0]   high_water;
    logic            is_live;
    logic [IDW-1:0]  nid;
    logic [EXTW-1:0] nid_ext;

    t_record         rec_rd, rec_wdata;
    logic            rec_we;
    logic [IDW-1:0]  rec_waddr;
    logic [IDW-1:0]  stk_rd;
    logic            stk_we;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign exec_done  = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    assign id_in_ext  = EXTW'(i_entry_id);
    assign depth_m1   = r_depth - CW'(1);
    // live + stacked IDs are exactly the IDs handed out since reset
    assign high_water = r_live + r_depth;
    assign is_live    = (CMPW'(r_id) < CMPW'(high_water)) && rec_rd.valid;
    assign nid_ext    = EXTW'(nid);

    rtidr_ram #(
        .WIDTH (REC_W),
        .DEPTH (CAPACITY)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_waddr (rec_waddr),
        .i_wdata (rec_wdata),
        .i_re    (in_xfer),
        .i_raddr (id_in_ext[IDW-1:0]),
        .o_rdata (rec_rd)
    );

    rtidr_ram #(
        .WIDTH (IDW),
        .DEPTH (CAPACITY)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_depth[IDW-1:0]),
        .i_wdata (r_id[IDW-1:0]),
        .i_re    (in_xfer),
        .i_raddr (depth_m1[IDW-1:0]),
        .o_rdata (stk_rd)
    );

    always_comb begin
        n_status  = ST_INVALID;
        n_rid     = '0;
        n_fp      = '0;
        n_fd      = '0;
        n_fdate   = '0;
        n_ftime   = '0;
        n_live    = r_live;
        n_depth   = r_depth;
        nid       = r_live[IDW-1:0];
        rec_we    = 1'b0;
        rec_waddr = r_id[IDW-1:0];
        rec_wdata = rec_rd;
        stk_we    = 1'b0;
        unique case (r_cmd)
            CMD_ADD: begin
                if (r_patient[KEY_W-1] || r_doctor[KEY_W-1]) begin
                    n_status = ST_INVALID;
                end else if (r_depth != '0 || r_live < CW'(CAPACITY)) begin
                    if (r_depth != '0) begin
                        nid     = stk_rd;
                        n_depth = depth_m1;
                    end
                    rec_we    = exec_done;
                    rec_waddr = nid;
                    rec_wdata = '{valid:   1'b1,
                                  patient: r_patient[OWNER_W-1:0],
                                  doctor:  r_doctor[OWNER_W-1:0],
                                  date:    r_date,
                                  tim:     r_time};
                    n_live    = r_live + CW'(1);
                    n_status  = ST_OK;
                    n_rid     = nid_ext[ID_W-1:0];
                end else begin
                    n_status = ST_FULL;
                end
            end
            CMD_REMOVE: begin
                if (is_live) begin
                    rec_we          = exec_done;
                    rec_wdata.valid = 1'b0;
                    if (r_depth < CW'(CAPACITY)) begin
                        stk_we  = exec_done;
                        n_depth = r_depth + CW'(1);
                    end
                    if (r_live != '0) begin
                        n_live = r_live - CW'(1);
                    end
                    n_status = ST_OK;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            CMD_LOOKUP: begin
                if (is_live) begin
                    n_status = ST_OK;
                    n_rid    = r_id[ID_W-1:0];
                    n_fp     = rec_rd.patient;
                    n_fd     = rec_rd.doctor;
                    n_fdate  = rec_rd.date;
                    n_ftime  = rec_rd.tim;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_xfer) n_state = S_EXEC;
            S_EXEC: if (exec_done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_live      <= '0;
            r_depth     <= '0;
        end else begin
            r_state <= n_state;
            if (exec_done) begin
                r_out_valid <= 1'b1;
                r_live      <= n_live;
                r_depth     <= n_depth;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd     <= t_cmd'(i_cmd);
            r_id      <= id_in_ext;
            r_patient <= i_patient_key;
            r_doctor  <= i_doctor_key;
            r_date    <= i_date_chars;
            r_time    <= i_time_chars;
        end
        if (exec_done) begin
            r_status <= n_status;
            r_rid    <= n_rid;
            r_fp     <= n_fp;
            r_fd     <= n_fd;
            r_fdate  <= n_fdate;
            r_ftime  <= n_ftime;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_result_id     = r_rid;
    assign o_found_patient = r_fp;
    assign o_found_doctor  = r_fd;
    assign o_found_date    = r_fdate;
    assign o_found_time    = r_ftime;

endmodule

FILE: sv/rtidr_checker.sv
`include "record_table_with_id_recycling_assert.svh"

module rtidr_checker
    import rtidr_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic [STATUS_W-1:0] o_status,
    input logic [ID_W-1:0]     o_result_id,
    input logic [OWNER_W-1:0]  o_found_patient,
    input logic [OWNER_W-1:0]  o_found_doctor,
    input logic [DATE_W-1:0]   o_found_date,
    input logic [TIME_W-1:0]   o_found_time
);

    logic in_xfer;
    logic out_stall;

    assign in_xfer   = i_in_valid && o_in_ready;
    assign out_stall = o_out_valid && !i_out_ready;

    // one command in flight: ready drops right after a transfer
    `RTIDR_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, in_xfer, !o_in_ready)

    // failed commands return an all-zero payload
    `RTIDR_ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, o_out_valid && o_status != ST_OK, (o_result_id == '0) && (o_found_patient == '0) && (o_found_doctor == '0) && (o_found_date == '0) && (o_found_time == '0))

    // a stalled result holds
    `RTIDR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_status) && $stable(o_result_id) && $stable(o_found_date))

endmodule

bind record_table_with_id_recycling rtidr_checker u_rtidr_checker (.*);

FILE: verif/record_table_with_id_recycling_tb.sv
module record_table_with_id_recycling_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rtidr_pkg::*;

    localparam int DEPTH = 256;

    typedef struct packed {
        t_status             status;
        logic [ID_W-1:0]     id;
        logic [OWNER_W-1:0]  patient;
        logic [OWNER_W-1:0]  doctor;
        logic [DATE_W-1:0]   date;
        logic [TIME_W-1:0]   tim;
    } t_response;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [CMD_W-1:0]    i_cmd = '0;
    logic [ID_W-1:0]     i_entry_id = '0;
    logic [KEY_W-1:0]    i_patient_key = '0;
    logic [KEY_W-1:0]    i_doctor_key = '0;
    logic [DATE_W-1:0]   i_date_chars = '0;
    logic [TIME_W-1:0]   i_time_chars = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [ID_W-1:0]     o_result_id;
    logic [OWNER_W-1:0]  o_found_patient;
    logic [OWNER_W-1:0]  o_found_doctor;
    logic [DATE_W-1:0]   o_found_date;
    logic [TIME_W-1:0]   o_found_time;

    record_table_with_id_recycling dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_entry_id      (i_entry_id),
        .i_patient_key   (i_patient_key),
        .i_doctor_key    (i_doctor_key),
        .i_date_chars    (i_date_chars),
        .i_time_chars    (i_time_chars),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_result_id     (o_result_id),
        .o_found_patient (o_found_patient),
        .o_found_doctor  (o_found_doctor),
        .o_found_date    (o_found_date),
        .o_found_time    (o_found_time)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted table contents
    bit                 slot_live    [DEPTH];
    logic [OWNER_W-1:0] slot_patient [DEPTH];
    logic [OWNER_W-1:0] slot_doctor  [DEPTH];
    logic [DATE_W-1:0]  slot_date    [DEPTH];
    logic [TIME_W-1:0]  slot_time    [DEPTH];
    int                 free_ids[$];   // LIFO: push_back / pop_back
    int                 live_count = 0;
    int                 peak_live = 0;

    t_response pending_responses[$];

    int  error_count = 0;
    int  n_cmd[4] = '{default: 0};
    int  n_status[4] = '{default: 0};
    bit  idle_enabled = 1'b1;
    int  burst_left = 0;

    function automatic t_response compute_response(t_cmd cmd, logic [ID_W-1:0] id,
                                                   logic [KEY_W-1:0] pk, logic [KEY_W-1:0] dk,
                                                   logic [DATE_W-1:0] date,
                                                   logic [TIME_W-1:0] tim);
        t_response r;
        int        nid;
        r = '0;
        r.status = ST_INVALID;
        case (cmd)
            CMD_ADD: begin
                if (pk[KEY_W-1] || dk[KEY_W-1]) begin
                    r.status = ST_INVALID;
                end else if (free_ids.size() > 0 || live_count < DEPTH) begin
                    if (free_ids.size() > 0) nid = free_ids.pop_back();
                    else nid = live_count;
                    slot_live[nid]    = 1'b1;
                    slot_patient[nid] = pk[OWNER_W-1:0];
                    slot_doctor[nid]  = dk[OWNER_W-1:0];
                    slot_date[nid]    = date;
                    slot_time[nid]    = tim;
                    live_count++;
                    if (live_count > peak_live) peak_live = live_count;
                    r.status = ST_OK;
                    r.id = nid[ID_W-1:0];
                end else begin
                    r.status = ST_FULL;
                end
            end
            CMD_REMOVE: begin
                if (slot_live[id]) begin
                    slot_live[id] = 1'b0;
                    free_ids.push_back(int'(id));
                    live_count--;
                    r.status = ST_OK;
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            CMD_LOOKUP: begin
                if (slot_live[id]) begin
                    r.status  = ST_OK;
                    r.id      = id;
                    r.patient = slot_patient[id];
                    r.doctor  = slot_doctor[id];
                    r.date    = slot_date[id];
                    r.tim     = slot_time[id];
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            default: r.status = ST_INVALID;
        endcase
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'h7fff_ffff;
            default: return $urandom & 32'h7fff_ffff;
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] bad_key();
        return $urandom | 32'h8000_0000;
    endfunction

    function automatic logic [DATE_W-1:0] random_date();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [TIME_W-1:0] random_time();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[TIME_W-1:0];
    endfunction

    // Mostly a live ID so removes and lookups hit, otherwise any ID
    function automatic logic [ID_W-1:0] pick_id();
        int start;
        start = $urandom_range(0, DEPTH - 1);
        if (live_count > 0 && $urandom_range(0, 9) < 8) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (slot_live[(start + i) % DEPTH]) return ID_W'((start + i) % DEPTH);
            end
        end
        return start[ID_W-1:0];
    endfunction

    task automatic send_command(t_cmd cmd, logic [ID_W-1:0] id, logic [KEY_W-1:0] pk,
                                logic [KEY_W-1:0] dk, logic [DATE_W-1:0] date,
                                logic [TIME_W-1:0] tim);
        int gap;
        @(negedge i_clk);
        if (idle_enabled && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        if (burst_left > 0) burst_left--;
        i_cmd         <= cmd;
        i_entry_id    <= id;
        i_patient_key <= pk;
        i_doctor_key  <= dk;
        i_date_chars  <= date;
        i_time_chars  <= tim;
        i_in_valid    <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pending_responses.push_back(compute_response(cmd, id, pk, dk, date, tim));
        n_cmd[int'(cmd)]++;
    endtask

    task automatic send_random_item(int add_pct, int remove_pct);
        int               roll;
        t_cmd             cmd;
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] pk;
        logic [KEY_W-1:0] dk;
        roll = $urandom_range(0, 99);
        pk = random_key();
        dk = random_key();
        id = pick_id();
        if (roll < 8) begin
            case ($urandom_range(0, 3))
                0: begin
                    cmd = CMD_RSVD;
                    pk = $urandom;
                    dk = $urandom;
                end
                1: begin
                    cmd = CMD_ADD;
                    pk = bad_key();
                end
                2: begin
                    cmd = CMD_ADD;
                    dk = bad_key();
                end
                default: begin
                    cmd = roll[0] ? CMD_REMOVE : CMD_LOOKUP;
                    id = ID_W'($urandom_range(0, DEPTH - 1));
                end
            endcase
        end else if (roll < 8 + add_pct) begin
            cmd = CMD_ADD;
        end else if (roll < 8 + add_pct + remove_pct) begin
            cmd = CMD_REMOVE;
        end else begin
            cmd = CMD_LOOKUP;
        end
        send_command(cmd, id, pk, dk, random_date(), random_time());
    endtask

    // Hold the sender off until every outstanding response is back
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_responses.size() > 0) @(posedge i_clk);
    endtask

    task automatic test_basic_commands();
        idle_enabled = 1'b1;
        send_command(CMD_LOOKUP, 8'd0, '0, '0, '0, '0);
        send_command(CMD_REMOVE, 8'd0, '0, '0, '0, '0);
        send_command(CMD_LOOKUP, 8'hff, '1, '1, '1, '1);
        send_command(CMD_ADD, 8'hff, '0, '0, '0, '0);
        send_command(CMD_ADD, 8'h00, 32'h7fff_ffff, 32'h7fff_ffff, '1, '1);
        send_command(CMD_ADD, 8'd0, 32'h8000_0000, 32'd0, '1, '0);
        send_command(CMD_ADD, 8'd0, 32'd0, 32'hffff_ffff, '0, '1);
        send_command(CMD_ADD, 8'd0, 32'hffff_ffff, 32'hffff_ffff, '1, '1);
        send_command(CMD_RSVD, 8'hff, '1, '1, '1, '1);
        send_command(CMD_RSVD, 8'd0, '0, '0, '0, '0);
        send_command(CMD_LOOKUP, 8'd0, '1, '1, '1, '1);
        send_command(CMD_LOOKUP, 8'd1, '0, '0, '0, '0);
        send_command(CMD_LOOKUP, 8'd2, '0, '0, '0, '0);
        // ASCII "31122099" and "235959"
        send_command(CMD_ADD, 8'd7, 32'd12345, 32'd678, 64'h3331_3132_3230_3939,
                     48'h3233_3539_3539);
        send_command(CMD_LOOKUP, 8'd2, '0, '0, '0, '0);
        send_command(CMD_REMOVE, 8'd1, '0, '0, '0, '0);
        send_command(CMD_REMOVE, 8'd1, '0, '0, '0, '0);
        send_command(CMD_LOOKUP, 8'd1, '0, '0, '0, '0);
        send_command(CMD_REMOVE, 8'd0, '0, '0, '0, '0);
        // freed IDs come back last-in first-out, then the count takes over
        send_command(CMD_ADD, 8'd0, random_key(), random_key(), random_date(), random_time());
        send_command(CMD_ADD, 8'd0, random_key(), random_key(), random_date(), random_time());
        send_command(CMD_ADD, 8'd0, random_key(), random_key(), random_date(), random_time());
        send_command(CMD_LOOKUP, 8'd3, '0, '0, '0, '0);
        send_command(CMD_LOOKUP, 8'd0, '0, '0, '0, '0);
    endtask

    task automatic test_random_mix();
        idle_enabled = 1'b1;
        repeat (220) send_random_item(40, 30);
    endtask

    task automatic test_fill_to_capacity();
        while (live_count < DEPTH) begin
            idle_enabled = (live_count > DEPTH / 2);
            send_random_item(85, 3);
        end
    endtask

    task automatic test_full_table();
        idle_enabled = 1'b1;
        repeat (4) begin
            send_command(CMD_ADD, ID_W'($urandom), random_key(), random_key(),
                         random_date(), random_time());
        end
        send_command(CMD_LOOKUP, 8'hff, '0, '0, '0, '0);
        send_command(CMD_REMOVE, 8'hff, '0, '0, '0, '0);
        send_command(CMD_ADD, 8'd0, random_key(), random_key(), random_date(), random_time());
        send_command(CMD_ADD, 8'd0, random_key(), random_key(), random_date(), random_time());
        send_command(CMD_LOOKUP, 8'hff, '0, '0, '0, '0);
    endtask

    task automatic test_recycle_near_full();
        idle_enabled = 1'b1;
        repeat (80) send_random_item(35, 35);
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_responses
        t_response want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_responses.size() == 0) begin
                $error("response with none outstanding: status %0d", o_status);
                error_count++;
            end else begin
                want = pending_responses.pop_front();
                check_field("status", 64'(want.status), 64'(o_status));
                check_field("result_id", 64'(want.id), 64'(o_result_id));
                check_field("found_patient", 64'(want.patient), 64'(o_found_patient));
                check_field("found_doctor", 64'(want.doctor), 64'(o_found_doctor));
                check_field("found_date", want.date, o_found_date);
                check_field("found_time", 64'(want.tim), 64'(o_found_time));
            end
            n_status[o_status]++;
        end
    end

    // Receiver backpressure: a 16-bit pattern indexed by a 6-bit phase, redrawn when the phase wraps
    always @(negedge i_clk) begin : drive_out_ready
        logic [15:0] stall_pattern;
        logic [5:0]  stall_phase;
        if (stall_phase === 6'bx) stall_phase = '0;
        if (stall_phase == 6'd0) begin
            if ($urandom_range(0, 3) == 0) stall_pattern = '1;
            else stall_pattern = 16'($urandom) | 16'h0001;
        end
        i_out_ready <= stall_pattern[stall_phase[3:0]];
        stall_phase = stall_phase + 1'b1;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_commands();
        wait_for_drain();
        test_random_mix();
        wait_for_drain();
        test_fill_to_capacity();
        test_full_table();
        wait_for_drain();
        test_recycle_near_full();
        wait_for_drain();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d adds, %0d removes, %0d lookups, %0d reserved; peak live entries %0d",
                 n_cmd[CMD_ADD], n_cmd[CMD_REMOVE], n_cmd[CMD_LOOKUP], n_cmd[CMD_RSVD],
                 peak_live);
        $display("Responses: %0d ok, %0d not found, %0d invalid, %0d full",
                 n_status[ST_OK], n_status[ST_NOT_FOUND], n_status[ST_INVALID],
                 n_status[ST_FULL]);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
